>>> rtl/sism_pkg.sv
// ----------------------------------------------------------------------------
// sism_pkg
// Types, codes and helper functions shared by the shader issue stall model.
// ----------------------------------------------------------------------------
package sism_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned CD_W  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register file codes
  localparam logic [1:0] RF_R    = 2'd0;
  localparam logic [1:0] RF_V    = 2'd1;
  localparam logic [1:0] RF_X    = 2'd2;
  localparam logic [1:0] RF_NONE = 2'd3;

  // pipe classes
  localparam logic [2:0] PIPE_NONE    = 3'd0;
  localparam logic [2:0] PIPE_ADD     = 3'd1;
  localparam logic [2:0] PIPE_MUL     = 3'd2;
  localparam logic [2:0] PIPE_CMP     = 3'd3;
  localparam logic [2:0] PIPE_CNV     = 3'd4;
  localparam logic [2:0] PIPE_SHIFT   = 3'd5;
  localparam logic [2:0] PIPE_BIT     = 3'd6;
  localparam logic [2:0] PIPE_SPECIAL = 3'd7;

  localparam logic [CD_W-1:0] LAT_NONE    = 4'd1;
  localparam logic [CD_W-1:0] LAT_ADD     = 4'd4;
  localparam logic [CD_W-1:0] LAT_MUL     = 4'd5;
  localparam logic [CD_W-1:0] LAT_CMP     = 4'd1;
  localparam logic [CD_W-1:0] LAT_CNV     = 4'd3;
  localparam logic [CD_W-1:0] LAT_SHIFT   = 4'd1;
  localparam logic [CD_W-1:0] LAT_BIT     = 4'd1;
  localparam logic [CD_W-1:0] LAT_SPECIAL = 4'd14;

  typedef struct packed {
    logic       valid;
    logic [1:0] quad;
    logic [1:0] rtype;
    logic [2:0] idx;
    logic [1:0] chan;
  } slot_t;

  localparam slot_t SLOT_CLEAR = '{valid: 1'b0, quad: 2'd0, rtype: RF_X,
                                   idx: 3'd7, chan: 2'd0};

  typedef struct packed {
    logic [2:0] exe_pipe;
    logic       is_end;
    logic [1:0] dest_type;
    logic [2:0] dest_index;
    logic [1:0] dest_chan;
    logic [1:0] srca_type;
    logic [2:0] srca_index;
    logic [1:0] srca_chan;
    logic [1:0] srcb_type;
    logic [2:0] srcb_index;
    logic [1:0] srcb_chan;
  } instr_t;

  typedef struct packed {
    logic [CNT_W-1:0] cycles_used;
    logic [CNT_W-1:0] collision_stalls;
    logic [CNT_W-1:0] hazard_stalls;
    logic [CNT_W-1:0] total_cycles;
    logic [CNT_W-1:0] total_wasted;
    logic             finished;
  } result_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;      // latch a new instruction, clear per-request counts
    logic skip;      // request after END: report totals only
    logic step;      // simulate one cycle
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic issue;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [CD_W-1:0] pipe_latency(input logic [2:0] pipe);
    logic [CD_W-1:0] lat;
    case (pipe)
      PIPE_NONE:    lat = LAT_NONE;
      PIPE_ADD:     lat = LAT_ADD;
      PIPE_MUL:     lat = LAT_MUL;
      PIPE_CMP:     lat = LAT_CMP;
      PIPE_CNV:     lat = LAT_CNV;
      PIPE_SHIFT:   lat = LAT_SHIFT;
      PIPE_BIT:     lat = LAT_BIT;
      PIPE_SPECIAL: lat = LAT_SPECIAL;
      default:      lat = LAT_NONE;
    endcase
    return lat;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
    return (a == CNT_MAX) ? a : a + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

  function automatic logic src_hit(input slot_t s, input logic [1:0] t,
                                   input logic [2:0] i, input logic [1:0] c);
    return s.valid && (s.quad == 2'd0) && (s.rtype == t) && (s.idx == i) &&
           (s.chan == c);
  endfunction

endpackage

>>> rtl/sism_in_if.sv
// ----------------------------------------------------------------------------
// sism_in_if
// Instruction request channel: valid/ready with decoded instruction fields.
// ----------------------------------------------------------------------------
interface sism_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] exe_pipe;
  logic       is_end;
  logic [1:0] dest_type;
  logic [2:0] dest_index;
  logic [1:0] dest_chan;
  logic [1:0] srca_type;
  logic [2:0] srca_index;
  logic [1:0] srca_chan;
  logic [1:0] srcb_type;
  logic [2:0] srcb_index;
  logic [1:0] srcb_chan;

  modport source (
    output valid, exe_pipe, is_end, dest_type, dest_index, dest_chan,
           srca_type, srca_index, srca_chan, srcb_type, srcb_index, srcb_chan,
    input  ready
  );

  modport sink (
    input  valid, exe_pipe, is_end, dest_type, dest_index, dest_chan,
           srca_type, srca_index, srca_chan, srcb_type, srcb_index, srcb_chan,
    output ready
  );
endinterface

>>> rtl/sism_out_if.sv
// ----------------------------------------------------------------------------
// sism_out_if
// Result request channel: valid/ready with cycle and stall counts.
// ----------------------------------------------------------------------------
interface sism_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cycles_used;
  logic [15:0] collision_stalls;
  logic [15:0] hazard_stalls;
  logic [15:0] total_cycles;
  logic [15:0] total_wasted;
  logic        finished;

  modport source (
    output valid, cycles_used, collision_stalls, hazard_stalls, total_cycles,
           total_wasted, finished,
    input  ready
  );

  modport sink (
    input  valid, cycles_used, collision_stalls, hazard_stalls, total_cycles,
           total_wasted, finished,
    output ready
  );
endinterface

>>> rtl/sism_ctrl.sv
// ----------------------------------------------------------------------------
// sism_ctrl
// Sequencer: accepts a request, steps sim cycles until issue; skips after END.
// ----------------------------------------------------------------------------
module sism_ctrl
  import sism_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (sts.done) begin
            cmd.skip = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // hold while the previous result is still waiting
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.issue) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/sism_datapath.sv
// ----------------------------------------------------------------------------
// sism_datapath
// Write-slot shift line, collision and hazard checks, counters and result.
// ----------------------------------------------------------------------------
module sism_datapath
  import sism_pkg::*;
#(
  parameter int STAGES       = 23,
  parameter int READ_LATENCY = 3,
  parameter int MIN_SLOT     = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  input  instr_t    instr,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   res
);

  // wide enough for any stage index and for base + 3
  localparam int IW = $clog2(STAGES + READ_LATENCY + 19);

  slot_t            slots_r [STAGES];
  slot_t            slots_nxt [STAGES];
  slot_t            sh [STAGES];
  logic [STAGES-1:0] win_r;
  logic [STAGES-1:0] win_nxt;
  logic [1:0]       quad_r [STAGES];
  logic [1:0]       quad_nxt [STAGES];
  instr_t           ins_r;
  logic [CD_W-1:0]  lat_r;
  logic [CD_W-1:0]  lat_in;
  logic [IW-1:0]    base;
  logic [IW-1:0]    diff [STAGES];
  logic [CD_W-1:0]  cd_r;
  logic [CNT_W-1:0] used_r;
  logic [CNT_W-1:0] coll_r;
  logic [CNT_W-1:0] haz_r;
  logic [CNT_W-1:0] cyc_tot_r;
  logic [CNT_W-1:0] coll_tot_r;
  logic [CNT_W-1:0] haz_tot_r;
  logic             done_r;
  logic             out_valid_r;
  result_t          res_r;
  logic             coll_hit;
  logic             hit_a;
  logic             hit_b;
  logic             haz_hit;
  logic             cd_zero;
  logic             issue;

  // window of the four quad-write stages, set up when a request is taken
  always_comb begin
    lat_in = pipe_latency(instr.exe_pipe);
    base   = IW'(lat_in) + IW'(READ_LATENCY) + IW'(1);
    for (int s = 0; s < STAGES; s++) begin
      diff[s]     = IW'(s) - base;
      win_nxt[s]  = (diff[s][IW-1:2] == '0);
      quad_nxt[s] = diff[s][1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < STAGES - 1; i++) begin
      sh[i] = slots_r[i+1];
    end
    sh[STAGES-1] = SLOT_CLEAR;
  end

  always_comb begin
    coll_hit = 1'b0;
    hit_a    = 1'b0;
    hit_b    = 1'b0;
    for (int s = 0; s < STAGES; s++) begin
      coll_hit = coll_hit | (sh[s].valid & win_r[s]);
    end
    // last stage is outside the hazard window
    for (int i = 0; i < STAGES - 1; i++) begin
      hit_a = hit_a | src_hit(sh[i], ins_r.srca_type, ins_r.srca_index,
                              ins_r.srca_chan);
      hit_b = hit_b | src_hit(sh[i], ins_r.srcb_type, ins_r.srcb_index,
                              ins_r.srcb_chan);
    end
    haz_hit = (hit_a && (ins_r.srca_type != RF_NONE)) ||
              (hit_b && (ins_r.srcb_type != RF_NONE));
    cd_zero = (cd_r == '0);
    issue   = cd_zero && !coll_hit && !haz_hit;
  end

  always_comb begin
    for (int s = 0; s < STAGES; s++) begin
      if (issue && win_r[s]) begin
        if (ins_r.dest_type != RF_NONE) begin
          slots_nxt[s] = '{valid: 1'b1, quad: quad_r[s], rtype: ins_r.dest_type,
                           idx: ins_r.dest_index, chan: ins_r.dest_chan};
        end else begin
          slots_nxt[s] = SLOT_CLEAR;
        end
      end else begin
        slots_nxt[s] = sh[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) begin
        slots_r[s] <= SLOT_CLEAR;
      end
    end else if (cmd.step) begin
      for (int s = 0; s < STAGES; s++) begin
        slots_r[s] <= slots_nxt[s];
      end
    end
  end

  // request fields and window need no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ins_r <= instr;
      lat_r <= lat_in;
      win_r <= win_nxt;
      for (int s = 0; s < STAGES; s++) begin
        quad_r[s] <= quad_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r       <= '0;
      used_r     <= '0;
      coll_r     <= '0;
      haz_r      <= '0;
      cyc_tot_r  <= '0;
      coll_tot_r <= '0;
      haz_tot_r  <= '0;
      done_r     <= 1'b0;
    end else if (cmd.load) begin
      used_r <= '0;
      coll_r <= '0;
      haz_r  <= '0;
    end else if (cmd.step) begin
      used_r    <= sat_inc(used_r);
      cyc_tot_r <= sat_inc(cyc_tot_r);
      if (!cd_zero) begin
        cd_r <= cd_r - 1'b1;
      end else if (coll_hit) begin
        coll_r     <= sat_inc(coll_r);
        coll_tot_r <= sat_inc(coll_tot_r);
      end else if (haz_hit) begin
        haz_r     <= sat_inc(haz_r);
        haz_tot_r <= sat_inc(haz_tot_r);
      end else if (ins_r.is_end) begin
        done_r <= 1'b1;
      end else begin
        cd_r <= (lat_r < CD_W'(MIN_SLOT)) ? CD_W'(MIN_SLOT) : lat_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.skip || (cmd.step && issue)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.skip) begin
      res_r.cycles_used      <= '0;
      res_r.collision_stalls <= '0;
      res_r.hazard_stalls    <= '0;
      res_r.total_cycles     <= cyc_tot_r;
      res_r.total_wasted     <= sat_add(coll_tot_r, haz_tot_r);
      res_r.finished         <= 1'b1;
    end else if (cmd.step && issue) begin
      res_r.cycles_used      <= sat_inc(used_r);
      res_r.collision_stalls <= coll_r;
      res_r.hazard_stalls    <= haz_r;
      res_r.total_cycles     <= sat_inc(cyc_tot_r);
      res_r.total_wasted     <= sat_add(coll_tot_r, haz_tot_r);
      res_r.finished         <= ins_r.is_end;
    end
  end

  assign sts.done     = done_r;
  assign sts.issue    = issue;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign res          = res_r;

endmodule

>>> rtl/shader_issue_stall_model_top.sv
// Timing: the request is latched at the accepting edge, then one simulated cycle
//   per clock while results drain; the result register loads at the issue edge.
// Throughput: a new request is taken only after the previous one issues; the
//   write-slot shift line steps while results drain; after END, one per clock.
// Reset: synchronous, active low; clears slot valids, countdown, totals and
//   the END flag.
// ----------------------------------------------------------------------------
// shader_issue_stall_model_top
// Shader issue stall model: per-instruction cycle and stall accounting.
// ----------------------------------------------------------------------------
module shader_issue_stall_model_top
  import sism_pkg::*;
#(
  parameter int STAGES       = 23,
  parameter int READ_LATENCY = 3,
  parameter int MIN_SLOT     = 7
) (
  input logic         clk,
  input logic         rst_n,
  sism_in_if.sink     in_ch,
  sism_out_if.source  out_ch
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  instr_t    instr;
  result_t   res;

  assign instr = '{exe_pipe:   in_ch.exe_pipe,
                   is_end:     in_ch.is_end,
                   dest_type:  in_ch.dest_type,
                   dest_index: in_ch.dest_index,
                   dest_chan:  in_ch.dest_chan,
                   srca_type:  in_ch.srca_type,
                   srca_index: in_ch.srca_index,
                   srca_chan:  in_ch.srca_chan,
                   srcb_type:  in_ch.srcb_type,
                   srcb_index: in_ch.srcb_index,
                   srcb_chan:  in_ch.srcb_chan};

  sism_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sism_datapath #(
    .STAGES       (STAGES),
    .READ_LATENCY (READ_LATENCY),
    .MIN_SLOT     (MIN_SLOT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .instr     (instr),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.cycles_used      = res.cycles_used;
  assign out_ch.collision_stalls = res.collision_stalls;
  assign out_ch.hazard_stalls    = res.hazard_stalls;
  assign out_ch.total_cycles     = res.total_cycles;
  assign out_ch.total_wasted     = res.total_wasted;
  assign out_ch.finished         = res.finished;

endmodule
